// ===== rtl/core/etc1_block_decoder_unit_assert.svh =====
// Assertion macros shared by the ETC1 block decoder RTL.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef ETC1_BLOCK_DECODER_UNIT_ASSERT_SVH
`define ETC1_BLOCK_DECODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETC1_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ETC1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/etc1_pkg.sv =====
// Package for the ETC1 block decoder: constants, small types and the
// per-channel decode functions. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package etc1_pkg;

  localparam int unsigned MaxDim = 4096;

  localparam int unsigned DimW    = 13;  // width of the dimension registers
  localparam int unsigned BlkCntW = 10;  // block row and column counters
  localparam int unsigned BlkAcrW = 11;  // blocks across, up to MaxDim / 4
  localparam int unsigned CoordW  = 12;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixCntW = 4;   // sixteen pixels per block

  // Register indexes of the configuration port.
  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  localparam logic [DimW-1:0] DimResetVal = DimW'(4);

  typedef struct packed {
    logic [ChanW-1:0] b1;
    logic [ChanW-1:0] b0;
  } base_pair_t;

  // Number of 4x4 blocks across a dimension, after clamping the register
  // value into 1..MaxDim.
  function automatic logic [BlkAcrW-1:0] blocks_across(input logic [DimW-1:0] dim);
    logic [DimW-1:0] d;
    logic [DimW:0]   s;
    d = dim;
    if (d == '0) begin
      d = DimW'(1);
    end
    if (d > DimW'(MaxDim)) begin
      d = DimW'(MaxDim);
    end
    s = {1'b0, d} + (DimW+1)'(3);
    return BlkAcrW'(s >> 2);
  endfunction

  // Both base colors of one channel from its color byte.
  function automatic base_pair_t base_colors(input logic [7:0] b, input logic diff);
    base_pair_t bp;
    logic [4:0] c1;
    logic [4:0] c2;
    c1 = b[7:3];
    c2 = c1 + {{2{b[2]}}, b[2:0]};  // three-bit signed delta, wraps modulo 32
    if (diff) begin
      bp.b0 = {c1, c1[4:2]};
      bp.b1 = {c2, c2[4:2]};
    end else begin
      bp.b0 = {b[7:4], b[7:4]};
      bp.b1 = {b[3:0], b[3:0]};
    end
    return bp;
  endfunction

  // Modifier magnitude from the table selector and the index lsb.
  function automatic logic [7:0] mod_magnitude(input logic [2:0] tab, input logic lsb);
    logic [7:0] m;
    unique case ({tab, lsb})
      4'b000_0: m = 8'd2;
      4'b000_1: m = 8'd8;
      4'b001_0: m = 8'd5;
      4'b001_1: m = 8'd17;
      4'b010_0: m = 8'd9;
      4'b010_1: m = 8'd29;
      4'b011_0: m = 8'd13;
      4'b011_1: m = 8'd42;
      4'b100_0: m = 8'd18;
      4'b100_1: m = 8'd60;
      4'b101_0: m = 8'd24;
      4'b101_1: m = 8'd80;
      4'b110_0: m = 8'd33;
      4'b110_1: m = 8'd106;
      4'b111_0: m = 8'd47;
      4'b111_1: m = 8'd183;
      default:  m = 8'd0;
    endcase
    return m;
  endfunction

  // Base plus or minus the modifier, clamped into 0..255.
  function automatic logic [ChanW-1:0] apply_modifier(input logic [7:0] base,
                                                      input logic [7:0] mag,
                                                      input logic       neg);
    logic signed [9:0] s;
    logic [ChanW-1:0]  r;
    if (neg) begin
      s = $signed({2'b00, base}) - $signed({2'b00, mag});
    end else begin
      s = $signed({2'b00, base}) + $signed({2'b00, mag});
    end
    if (s < 0) begin
      r = '0;
    end else if (s > 10'sd255) begin
      r = 8'hFF;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/etc1_block_decoder_unit.sv =====
// Top level of the ETC1 block decoder: block buffer, pixel sequencer and
// registered pixel output. Depends on etc1_pkg and etc1_block_decoder_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The input channel (in_*) takes one 64-bit ETC1 block per beat, first stored
// byte in bits 63:56. The output channel (out_*) gives sixteen pixel beats per
// block in column-major order: coordinates, clamped RGB888, out_tlast on the
// sixteenth pixel and out_tuser on the sixteenth pixel of the image's last block.
// Blocks are placed left to right, top to bottom, over the image size set on the
// configuration port (cfg_*); writing either size register restarts placement at
// the top left block. The user must write sizes only while the block is idle;
// the block itself does not enforce this. Each input beat is stored in the
// one-block buffer, and its pixels are then decoded into the output register.
// Throughput: one pixel per cycle while the receiver does not stall, set by the
// one-block buffer and the single pixel sequencer. The next block is taken on the
// edge that loads the current block's last pixel, so blocks follow without gaps.
// When the receiver stalls, the output register holds its beat, the sequencer
// waits, and in_tready stays low until the buffered block is fully out.
// Reset (rst_n low at a clock edge) empties the buffer and the output register,
// sets both sizes to four pixels and returns the block counters to zero.

`include "etc1_block_decoder_unit_assert.svh"

module etc1_block_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [12:0] cfg_wdata,
  // Compressed block input.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] block_word
  // Decoded pixel output.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [11:0] pixel_x, [23:12] pixel_y,
                                       // [31:24] red, [39:32] green, [47:40] blue
  output logic             out_tlast,  // last_of_block
  output logic             out_tuser   // [0] last_of_image
);

  localparam int unsigned BlkCntW = etc1_pkg::BlkCntW;
  localparam int unsigned BlkAcrW = etc1_pkg::BlkAcrW;
  localparam int unsigned PixCntW = etc1_pkg::PixCntW;
  localparam int unsigned DimW    = etc1_pkg::DimW;
  localparam int unsigned ChanW   = etc1_pkg::ChanW;

  // Configuration and placement state.
  logic [DimW-1:0]    width_r,  width_nxt;
  logic [DimW-1:0]    height_r, height_nxt;
  logic [BlkCntW-1:0] col_r,    col_nxt;
  logic [BlkCntW-1:0] row_r,    row_nxt;

  // Block buffer and pixel sequencer.
  logic               blk_valid_r, blk_valid_nxt;
  logic [63:0]        blk_word_r;
  logic [BlkCntW-1:0] blk_col_r;
  logic [BlkCntW-1:0] blk_row_r;
  logic               blk_last_img_r;
  logic [PixCntW-1:0] pix_cnt_r, pix_cnt_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [47:0]        out_data_r;
  logic               out_last_r;
  logic               out_user_r;

  logic               in_fire;
  logic               out_free;
  logic               advance;
  logic               blk_done;
  logic [BlkAcrW-1:0] bw;
  logic [BlkAcrW-1:0] bh;
  logic               last_col;
  logic               last_row;

  // Pixel decode signals.
  logic [1:0]         px_x;
  logic [1:0]         px_y;
  logic               px_sub;
  logic               px_msb;
  logic               px_lsb;
  logic [2:0]         px_tab;
  logic [7:0]         px_mag;
  etc1_pkg::base_pair_t bp_r, bp_g, bp_b;
  logic [ChanW-1:0]   base_r, base_g, base_b;
  logic [ChanW-1:0]   pix_red, pix_green, pix_blue;

  // Handshake and sequencing.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = blk_valid_r && out_free;
  assign blk_done  = advance && (pix_cnt_r == '1);
  assign in_tready = !blk_valid_r || blk_done;
  assign in_fire   = in_tvalid && in_tready;

  // Block placement: the current counters describe the block being accepted.
  assign bw       = etc1_pkg::blocks_across(width_r);
  assign bh       = etc1_pkg::blocks_across(height_r);
  assign last_col = ({1'b0, col_r} + BlkAcrW'(1)) >= bw;
  assign last_row = ({1'b0, row_r} + BlkAcrW'(1)) >= bh;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_we) begin
      if (cfg_addr == etc1_pkg::RegImageWidth) begin
        width_nxt = cfg_wdata;
      end else begin
        height_nxt = cfg_wdata;
      end
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + BlkCntW'(1);
      end else begin
        col_nxt = col_r + BlkCntW'(1);
      end
    end
  end

  always_comb begin
    blk_valid_nxt = blk_valid_r;
    pix_cnt_nxt   = pix_cnt_r;
    if (advance) begin
      pix_cnt_nxt = pix_cnt_r + PixCntW'(1);  // wraps to zero after the last pixel
    end
    if (in_fire) begin
      blk_valid_nxt = 1'b1;
    end else if (blk_done) begin
      blk_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // Pixel decode for the current sequencer position. Pixel index is
  // column-major: x in the upper two bits, y in the lower two. The index
  // msbs start at bit 16 and the lsbs at bit 0.
  assign px_x   = pix_cnt_r[3:2];
  assign px_y   = pix_cnt_r[1:0];
  assign px_sub = blk_word_r[32] ? px_y[1] : px_x[1];
  assign px_msb = blk_word_r[{2'b01, pix_cnt_r}];
  assign px_lsb = blk_word_r[{2'b00, pix_cnt_r}];
  assign px_tab = px_sub ? blk_word_r[36:34] : blk_word_r[39:37];
  assign px_mag = etc1_pkg::mod_magnitude(px_tab, px_lsb);

  assign bp_r = etc1_pkg::base_colors(blk_word_r[63:56], blk_word_r[33]);
  assign bp_g = etc1_pkg::base_colors(blk_word_r[55:48], blk_word_r[33]);
  assign bp_b = etc1_pkg::base_colors(blk_word_r[47:40], blk_word_r[33]);

  assign base_r = px_sub ? bp_r.b1 : bp_r.b0;
  assign base_g = px_sub ? bp_g.b1 : bp_g.b0;
  assign base_b = px_sub ? bp_b.b1 : bp_b.b0;

  assign pix_red   = etc1_pkg::apply_modifier(base_r, px_mag, px_msb);
  assign pix_green = etc1_pkg::apply_modifier(base_g, px_mag, px_msb);
  assign pix_blue  = etc1_pkg::apply_modifier(base_b, px_mag, px_msb);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= etc1_pkg::DimResetVal;
      height_r    <= etc1_pkg::DimResetVal;
      col_r       <= '0;
      row_r       <= '0;
      blk_valid_r <= 1'b0;
      pix_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      blk_valid_r <= blk_valid_nxt;
      pix_cnt_r   <= pix_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      blk_word_r     <= in_tdata;
      blk_col_r      <= col_r;
      blk_row_r      <= row_r;
      blk_last_img_r <= last_col && last_row;
    end
    if (advance) begin
      out_data_r <= {pix_blue, pix_green, pix_red,
                     {blk_row_r, px_y}, {blk_col_r, px_x}};
      out_last_r <= (pix_cnt_r == '1);
      out_user_r <= (pix_cnt_r == '1) && blk_last_img_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  `ETC1_ASSERT_SAME(a_idle_cnt_zero, !blk_valid_r, pix_cnt_r == '0, "count not zero while idle")
  `ETC1_ASSERT_NEXT(a_accept_starts, in_fire, blk_valid_r && pix_cnt_r == '0, "block start wrong")
  `ETC1_ASSERT_NEXT(a_done_last, blk_done, out_tvalid && out_tlast, "block end not marked")
  `ETC1_ASSERT_SAME(a_user_implies_last, out_tvalid && out_tuser, out_tlast, "image end mid block")

endmodule

`default_nettype wire
